// ----- rtl/word_capitalization_classifier_defines.svh -----
// Assertion macros used by the classifier RTL.
// Each check is sampled on the rising edge of clk and held off during reset.
`ifndef WORD_CAPITALIZATION_CLASSIFIER_DEFINES_SVH
`define WORD_CAPITALIZATION_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define WCC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("word capitalization classifier check failed");

`define WCC_CHECK_OUT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("word capitalization classifier result check failed");

`else

`define WCC_CHECK(lbl, prop)

`define WCC_CHECK_OUT(lbl, prop)

`endif

`endif

// ----- rtl/wcc_pkg.sv -----
package wcc_pkg;

  // Parts that may be counted before the word reports overflow
  localparam int unsigned MAX_PARTS  = 16;
  // Parts that can pack a code into the 32-bit scheme word
  localparam int unsigned PACK_LIMIT = (MAX_PARTS < 16) ? MAX_PARTS : 16;

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned PARTS_W = 5;

  localparam logic [PARTS_W-1:0] PARTS_SAT      = 5'd30;
  localparam logic [LEN_W-1:0]   LEN_SAT        = 10'h3FF;
  localparam logic [31:0]        SCHEME_INVALID = 32'h0000_00FF;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 10'd32;

  // Configuration register map
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    CL_CAP = 2'd0,
    CL_LOW = 2'd1,
    CL_DLM = 2'd2,
    CL_BAD = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    PS_UNDEF = 3'd0,
    PS_LOWER = 3'd1,
    PS_TITLE = 3'd2,
    PS_UPPER = 3'd3,
    PS_CAP1  = 3'd4,
    PS_ERROR = 3'd5
  } pst_t;

  typedef enum logic [1:0] {
    SC_LOWER = 2'd0,
    SC_TITLE = 2'd1,
    SC_UPPER = 2'd2
  } scode_t;

  typedef struct packed {
    cls_t       cls;
    logic       is_zero;
    logic [7:0] lower;
  } cinfo_t;

  typedef struct packed {
    logic [7:0]         char_out;
    logic               done_res;
    logic [LEN_W-1:0]   word_length;
    logic [PARTS_W-1:0] part_count;
    logic [31:0]        scheme_bits;
    logic               word_valid;
    logic               overflow;
  } res_t;

  // Capitalization machine of one part
  function automatic pst_t next_part_state(input pst_t s, input cls_t c);
    pst_t n;
    n = PS_ERROR;
    unique case (s)
      PS_UNDEF: begin
        unique case (c)
          CL_CAP:  n = PS_CAP1;
          CL_LOW:  n = PS_LOWER;
          default: n = PS_ERROR;
        endcase
      end
      PS_LOWER: begin
        unique case (c)
          CL_LOW, CL_DLM: n = PS_LOWER;
          default:        n = PS_ERROR;
        endcase
      end
      PS_TITLE: begin
        unique case (c)
          CL_LOW, CL_DLM: n = PS_TITLE;
          default:        n = PS_ERROR;
        endcase
      end
      PS_UPPER: begin
        unique case (c)
          CL_CAP, CL_DLM: n = PS_UPPER;
          default:        n = PS_ERROR;
        endcase
      end
      PS_CAP1: begin
        unique case (c)
          CL_CAP, CL_DLM: n = PS_UPPER;
          CL_LOW:         n = PS_TITLE;
          default:        n = PS_ERROR;
        endcase
      end
      default: n = PS_ERROR;
    endcase
    return n;
  endfunction

  // Code packed for a closed part
  function automatic scode_t scheme_code(input pst_t s);
    scode_t r;
    r = SC_LOWER;
    unique case (s)
      PS_TITLE: r = SC_TITLE;
      PS_UPPER: r = SC_UPPER;
      default:  r = SC_LOWER;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/wcc_classify.sv -----
module wcc_classify (
  input  logic            [7:0] char_in,
  output wcc_pkg::cinfo_t       info
);
  import wcc_pkg::*;

  // Sort the byte into its class and fold capitals to lowercase
  always_comb begin
    info.is_zero = (char_in == 8'h00);
    priority if (char_in == 8'h00 || char_in == 8'h27 || char_in == 8'h2D) begin
      info.cls = CL_DLM;
    end else if (char_in == 8'h2C || char_in == 8'hB8 || char_in >= 8'hE0) begin
      info.cls = CL_LOW;
    end else if (char_in == 8'hA8 || char_in >= 8'hC0) begin
      info.cls = CL_CAP;
    end else begin
      info.cls = CL_BAD;
    end

    priority if (char_in[7:5] == 3'b110) begin
      info.lower = char_in | 8'h20;
    end else if (char_in == 8'hA8) begin
      info.lower = 8'hB8;
    end else begin
      info.lower = char_in;
    end
  end

endmodule

// ----- rtl/wcc_word_track.sv -----
`include "word_capitalization_classifier_defines.svh"

module wcc_word_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  wcc_pkg::cinfo_t             info,
  input  logic                        last,
  input  logic [wcc_pkg::LEN_W-1:0]   max_length,
  output wcc_pkg::res_t               res
);
  import wcc_pkg::*;

  pst_t               ps_r, ps_nxt;
  logic [PARTS_W-1:0] parts_r, parts_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic               valid_r, valid_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;

  logic [LEN_W-1:0]   len_inc;
  logic [PARTS_W-1:0] parts_upd;
  logic [31:0]        acc_upd;
  logic               valid_upd;
  logic [LEN_W-1:0]   len_upd;
  logic               ovf_upd;
  pst_t               ps_upd;
  pst_t               walk_st;
  pst_t               close_src;
  pst_t               close_st;
  logic               close_part;
  logic               is_delim;
  logic               done;

  // Walk the part machine and fold the byte into the word summary
  always_comb begin
    len_inc    = (len_r == LEN_SAT) ? len_r : len_r + 1'b1;
    walk_st    = next_part_state(ps_r, info.cls);
    is_delim   = (info.cls == CL_DLM) && !info.is_zero;
    done       = info.is_zero || last;
    ps_upd     = ps_r;
    parts_upd  = parts_r;
    acc_upd    = acc_r;
    valid_upd  = valid_r;
    len_upd    = len_r;
    ovf_upd    = ovf_r;
    close_part = 1'b0;
    close_src  = ps_r;

    priority if (info.is_zero) begin
      close_part = (ps_r != PS_UNDEF);
    end else if (is_delim) begin
      close_part = 1'b1;
      len_upd    = len_inc;
    end else begin
      close_part = last;
      close_src  = walk_st;
      ps_upd     = walk_st;
      len_upd    = len_inc;
    end

    close_st = next_part_state(close_src, CL_DLM);

    // Close the part: flag a bad part, else pack its code while the scheme word has room
    if (close_part) begin
      ps_upd = PS_UNDEF;
      if (close_st == PS_ERROR || close_st == PS_UNDEF) begin
        valid_upd = 1'b0;
      end else if (parts_r < PARTS_W'(PACK_LIMIT)) begin
        acc_upd = acc_r | (32'(scheme_code(close_st)) << {parts_r[3:0], 1'b0});
      end
    end

    // Count the delimiter, saturating at PARTS_SAT, and flag overflow past MAX_PARTS parts
    if (is_delim) begin
      if (({1'b0, parts_r} + 6'd2) > 6'(MAX_PARTS)) begin
        ovf_upd = 1'b1;
      end
      if (parts_r < PARTS_SAT) begin
        parts_upd = parts_r + 1'b1;
      end
    end
  end

  // Build the result
  always_comb begin
    res             = '0;
    res.char_out    = info.lower;
    res.done_res    = done;
    if (done) begin
      res.word_length = len_upd;
      res.part_count  = parts_upd + 1'b1;
      res.scheme_bits = valid_upd ? acc_upd : SCHEME_INVALID;
      res.word_valid  = valid_upd;
      res.overflow    = ovf_upd || (len_upd >= max_length);
    end
  end

  // Commit the update on each accepted byte; start a new word after the last byte
  always_comb begin
    ps_nxt    = ps_r;
    parts_nxt = parts_r;
    acc_nxt   = acc_r;
    valid_nxt = valid_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    if (upd) begin
      if (done) begin
        ps_nxt    = PS_UNDEF;
        parts_nxt = '0;
        acc_nxt   = '0;
        valid_nxt = 1'b1;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        ps_nxt    = ps_upd;
        parts_nxt = parts_upd;
        acc_nxt   = acc_upd;
        valid_nxt = valid_upd;
        len_nxt   = len_upd;
        ovf_nxt   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r    <= PS_UNDEF;
      parts_r <= '0;
      acc_r   <= '0;
      valid_r <= 1'b1;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      ps_r    <= ps_nxt;
      parts_r <= parts_nxt;
      acc_r   <= acc_nxt;
      valid_r <= valid_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `WCC_CHECK(a_clear_after_word, upd && done |=> len_r == '0 && parts_r == '0 && valid_r && !ovf_r)
  `WCC_CHECK(a_parts_saturate, parts_r <= PARTS_SAT)
  `WCC_CHECK(a_ovf_needs_parts, ovf_r |-> ({1'b0, parts_r} + 6'd1) >= 6'(MAX_PARTS))

endmodule

// ----- rtl/word_capitalization_classifier.sv -----
// Word capitalization classifier.
// Input channel (in_valid/in_ready): one byte of a single-byte Cyrillic word per
// request, in_last marking the final byte; a zero byte also ends the word.
// Result channel (out_valid/out_ready): one result per input byte, carrying the
// lowercased byte, and on the word's final byte the summary: length, part
// count, packed scheme (2 bits per part, 0xFF for an invalid word), valid flag
// and overflow flag. On other bytes the summary fields read zero.
// Configuration: APB-style port, register 0 at byte address 0 is max_length
// (10 bits, reset 32). Write it only while the block is idle.
// A request accepted on the input channel passes the input register, then the
// result register, before it shows on the result port.
// Throughput: one byte per cycle unless the receiver stalls; the byte classifier
// and the part machine are one short combinational step between both registers.
// Reset clears the word state and the valid flags of both register stages, and restores max_length.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until out_ready returns.
module word_capitalization_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_char_in,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_char_out,
  output logic                              out_done_res,
  output logic [wcc_pkg::LEN_W-1:0]         out_word_length,
  output logic [wcc_pkg::PARTS_W-1:0]       out_part_count,
  output logic [31:0]                       out_scheme_bits,
  output logic                              out_word_valid,
  output logic                              out_overflow,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import wcc_pkg::*;

  logic             s1_valid_r;
  logic [7:0]       s1_char_r;
  logic             s1_last_r;
  logic             out_valid_r;
  res_t             out_r;
  logic [LEN_W-1:0] max_length_r;
  logic             advance;
  logic             upd;
  cinfo_t           info;
  res_t             res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? 32'(max_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LENGTH) begin
      max_length_r <= pwdata[LEN_W-1:0];
    end
  end

  // Advance when the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign upd      = advance && s1_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_last;
    end
  end

  wcc_classify u_classify (
    .char_in (s1_char_r),
    .info    (info)
  );

  wcc_word_track u_word_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .info       (info),
    .last       (s1_last_r),
    .max_length (max_length_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_r.char_out;
  assign out_done_res    = out_r.done_res;
  assign out_word_length = out_r.word_length;
  assign out_part_count  = out_r.part_count;
  assign out_scheme_bits = out_r.scheme_bits;
  assign out_word_valid  = out_r.word_valid;
  assign out_overflow    = out_r.overflow;

endmodule
